// ===== design/mlfq_tick_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// MLFQ tick scheduler assertion macros
// Shared property forms for the scheduler's checkers, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MLFQ_TICK_SCHEDULER_ASSERT_SVH
`define MLFQ_TICK_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define MLFQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mlfq_tick_scheduler: same-cycle property failed");

// Next-cycle implication.
`define MLFQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mlfq_tick_scheduler: next-cycle property failed");

`endif

// ===== design/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// MLFQ scheduler package
// Sizes, command and register codes, and the item types shared by the
// scheduler modules.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  // Queue sizes. NUM_JOBS is a power of two so FIFO slot indexes wrap by
  // truncation.
  localparam int NUM_JOBS    = 8;
  localparam int NUM_LEVELS  = 4;
  localparam int LENGTH_BITS = 8;

  localparam int ID_W   = 3;
  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int SLOT_W = $clog2(NUM_JOBS);
  localparam int CNT_W  = $clog2(NUM_JOBS + 1);

  // Level FIFO memory holds every level's ring, addressed {level, slot}.
  localparam int FIFO_DEPTH = NUM_LEVELS * NUM_JOBS;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Job record memory holds {total, done} per job.
  localparam int JOB_REC_W = 2 * LENGTH_BITS;

  // Slice arithmetic saturates at 12 bits.
  localparam int              SLICE_W   = 12;
  localparam logic [SLICE_W-1:0] SLICE_MAX = '1;
  localparam int              BASE_W    = 4;

  // Configuration port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_SLICES = 1'd1;

  // Command codes.
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct packed {
    logic                   command;
    logic [ID_W-1:0]        job_id;
    logic [LENGTH_BITS-1:0] job_length;
    logic                   arrival_next_tick;
  } cmd_t;

  typedef struct packed {
    logic             idle;
    logic [ID_W-1:0]  ran_id;
    logic [LVL_W-1:0] ran_level;
    logic             finished;
    logic             demoted;
  } res_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [BASE_W-1:0]    data;
  } cfg_wr_t;

endpackage

// ===== design/mlfq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read; a same-address access returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/mlfq_slice.sv =====
// ----------------------------------------------------------------------------
// MLFQ slice unit
// Holds the slice configuration and a registered table of base powers, one
// multiply per level per cycle, settling after each configuration write.
// ----------------------------------------------------------------------------
module mlfq_slice (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mlfq_pkg::cfg_wr_t              cfg_i,
  input  logic [mlfq_pkg::LVL_W-1:0]     level_i,
  output logic [mlfq_pkg::SLICE_W-1:0]   slice_o,
  output logic                           settling_o
);

  localparam int PROD_W = mlfq_pkg::SLICE_W + mlfq_pkg::BASE_W;

  logic [mlfq_pkg::BASE_W-1:0]  base_q, base_d;
  logic                         exp_q, exp_d;
  logic [mlfq_pkg::SLICE_W-1:0] pow_q [mlfq_pkg::NUM_LEVELS];
  logic [mlfq_pkg::SLICE_W-1:0] pow_d [mlfq_pkg::NUM_LEVELS];
  logic [mlfq_pkg::LVL_W-1:0]   settle_q, settle_d;
  logic [mlfq_pkg::BASE_W-1:0]  base_eff;
  logic [PROD_W-1:0]            prod [mlfq_pkg::NUM_LEVELS];

  // A zero base behaves as one.
  assign base_eff = (base_q == '0) ? mlfq_pkg::BASE_W'(1) : base_q;

  // Register writes; any write restarts the settle count.
  always_comb begin
    base_d   = base_q;
    exp_d    = exp_q;
    settle_d = (settle_q != '0) ? settle_q - mlfq_pkg::LVL_W'(1) : settle_q;
    if (cfg_i.we) begin
      settle_d = mlfq_pkg::LVL_W'(mlfq_pkg::NUM_LEVELS - 1);
      unique case (cfg_i.idx)
        mlfq_pkg::REG_SLICE_BASE: base_d = cfg_i.data;
        mlfq_pkg::REG_EXP_SLICES: exp_d  = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Power table: entry l is base^l, saturated, built one level per cycle.
  always_comb begin
    pow_d[0]  = mlfq_pkg::SLICE_W'(1);
    prod[0]   = '0;
    for (int l = 1; l < mlfq_pkg::NUM_LEVELS; l++) begin
      prod[l]  = PROD_W'(pow_q[l-1]) * PROD_W'(base_eff);
      pow_d[l] = (prod[l] > PROD_W'(mlfq_pkg::SLICE_MAX)) ? mlfq_pkg::SLICE_MAX
                                                         : prod[l][mlfq_pkg::SLICE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= mlfq_pkg::BASE_W'(1);
      exp_q    <= 1'b0;
      settle_q <= '0;
      for (int l = 0; l < mlfq_pkg::NUM_LEVELS; l++) begin
        pow_q[l] <= mlfq_pkg::SLICE_W'(1);
      end
    end else begin
      base_q   <= base_d;
      exp_q    <= exp_d;
      settle_q <= settle_d;
      pow_q    <= pow_d;
    end
  end

  // Slice of the requested level.
  assign slice_o    = exp_q ? pow_q[level_i] : mlfq_pkg::SLICE_W'(base_eff);
  assign settling_o = (settle_q != '0);

endmodule

// ===== design/mlfq_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// MLFQ tick scheduler
// Result strobe path: an empty tick registers its result directly on accept;
// a tick with a job running goes through EXEC; a tick that dispatches a job
// goes through FETCH then EXEC (level FIFO memory read, then job record memory
// read); an arrive gives no result. Arrives and empty ticks leave busy_o low;
// other ticks hold busy_o until the result cycle; busy_o also holds while the
// slice table settles after a config write. The receiver cannot stall. Async reset empties queues.
// ----------------------------------------------------------------------------
module mlfq_tick_scheduler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  mlfq_pkg::cmd_t                      cmd_i,
  output logic                                done_o,
  output mlfq_pkg::res_t                      res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mlfq_pkg::BASE_W-1:0]         cfg_data_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  localparam int LB = mlfq_pkg::LENGTH_BITS;
  localparam logic [LB-1:0] LEN_MAX = '1;
  localparam logic [mlfq_pkg::CNT_W-1:0] CNT_FULL = mlfq_pkg::CNT_W'(mlfq_pkg::NUM_JOBS);
  localparam logic [mlfq_pkg::LVL_W-1:0] LVL_BOTTOM =
    mlfq_pkg::LVL_W'(mlfq_pkg::NUM_LEVELS - 1);

  logic [1:0]                    state_q, state_d;
  logic [mlfq_pkg::SLOT_W-1:0]   head_q [mlfq_pkg::NUM_LEVELS];
  logic [mlfq_pkg::SLOT_W-1:0]   head_d [mlfq_pkg::NUM_LEVELS];
  logic [mlfq_pkg::CNT_W-1:0]    cnt_q  [mlfq_pkg::NUM_LEVELS];
  logic [mlfq_pkg::CNT_W-1:0]    cnt_d  [mlfq_pkg::NUM_LEVELS];
  logic                          run_valid_q, run_valid_d;
  logic [mlfq_pkg::ID_W-1:0]     run_job_q, run_job_d;
  logic [mlfq_pkg::LVL_W-1:0]    run_lvl_q, run_lvl_d;
  logic [mlfq_pkg::SLICE_W-1:0]  used_q, used_d;
  logic                          anext_q, anext_d;
  logic [mlfq_pkg::NUM_JOBS-1:0] jvalid_q, jvalid_d;
  logic                          done_q, done_d;
  mlfq_pkg::res_t                res_q, res_d;

  logic                          accept;
  logic                          any_wait;
  logic [mlfq_pkg::LVL_W-1:0]    pick_lvl;

  logic                          fifo_we;
  logic [mlfq_pkg::FIFO_AW-1:0]  fifo_waddr, fifo_raddr;
  logic [mlfq_pkg::ID_W-1:0]     fifo_wdata, fifo_rdata;
  logic                          job_we;
  logic [mlfq_pkg::ID_W-1:0]     job_waddr, job_raddr;
  logic [mlfq_pkg::JOB_REC_W-1:0] job_wdata, job_rdata;

  logic [LB-1:0]                 rec_total, total, done_old, done_new;
  logic [mlfq_pkg::SLICE_W-1:0]  used_new, slice;
  logic                          fin, expired, can_dem, slice_busy;
  logic [mlfq_pkg::LVL_W-1:0]    new_lvl;
  mlfq_pkg::cfg_wr_t             cfg_wr;

  // Configuration goes straight to the slice unit.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = '{we: cfg_valid_i, idx: cfg_index_i, data: cfg_data_i};

  mlfq_slice u_slice (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_wr),
    .level_i    (run_lvl_q),
    .slice_o    (slice),
    .settling_o (slice_busy)
  );

  // Level FIFO slots and job records.
  mlfq_ram #(
    .WIDTH (mlfq_pkg::ID_W),
    .DEPTH (mlfq_pkg::FIFO_DEPTH)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (fifo_wdata),
    .raddr_i (fifo_raddr),
    .rdata_o (fifo_rdata)
  );

  mlfq_ram #(
    .WIDTH (mlfq_pkg::JOB_REC_W),
    .DEPTH (mlfq_pkg::NUM_JOBS)
  ) u_job_ram (
    .clk_i   (clk_i),
    .we_i    (job_we),
    .waddr_i (job_waddr),
    .wdata_i (job_wdata),
    .raddr_i (job_raddr),
    .rdata_o (job_rdata)
  );

  assign busy_o = (state_q != ST_IDLE) || slice_busy;
  assign accept = start_i && !busy_o;

  // Highest nonempty level, level 0 first.
  always_comb begin
    any_wait = 1'b0;
    pick_lvl = '0;
    for (int l = mlfq_pkg::NUM_LEVELS - 1; l >= 0; l--) begin
      if (cnt_q[l] != '0) begin
        any_wait = 1'b1;
        pick_lvl = mlfq_pkg::LVL_W'(l);
      end
    end
  end

  // Run one unit of the current job; records never written read as zero.
  assign rec_total = job_rdata[mlfq_pkg::JOB_REC_W-1:LB];
  assign total     = jvalid_q[run_job_q] ? rec_total : '0;
  assign done_old  = jvalid_q[run_job_q] ? job_rdata[LB-1:0] : '0;
  assign done_new  = (done_old == LEN_MAX) ? done_old : done_old + LB'(1);
  assign used_new  = (used_q == mlfq_pkg::SLICE_MAX) ? used_q
                                                     : used_q + mlfq_pkg::SLICE_W'(1);
  assign fin       = (done_new >= total);
  assign expired   = (used_new >= slice);
  assign can_dem   = (any_wait || anext_q) && (run_lvl_q != LVL_BOTTOM);
  assign new_lvl   = can_dem ? run_lvl_q + mlfq_pkg::LVL_W'(1) : run_lvl_q;

  // Command sequencer.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    run_valid_d = run_valid_q;
    run_job_d   = run_job_q;
    run_lvl_d   = run_lvl_q;
    used_d      = used_q;
    anext_d     = anext_q;
    jvalid_d    = jvalid_q;
    done_d      = 1'b0;
    res_d       = res_q;
    fifo_we     = 1'b0;
    fifo_waddr  = '0;
    fifo_wdata  = '0;
    fifo_raddr  = {pick_lvl, head_q[pick_lvl]};
    job_we      = 1'b0;
    job_waddr   = '0;
    job_wdata   = '0;
    job_raddr   = run_job_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i.command == mlfq_pkg::CMD_ARRIVE) begin
            // Push at the front of level 0 and reset the job record.
            if (cnt_q[0] < CNT_FULL) begin
              head_d[0]  = head_q[0] - mlfq_pkg::SLOT_W'(1);
              cnt_d[0]   = cnt_q[0] + mlfq_pkg::CNT_W'(1);
              fifo_we    = 1'b1;
              fifo_waddr = {mlfq_pkg::LVL_W'(0), head_d[0]};
              fifo_wdata = cmd_i.job_id;
              job_we     = 1'b1;
              job_waddr  = cmd_i.job_id;
              job_wdata  = {cmd_i.job_length, LB'(0)};
              jvalid_d[cmd_i.job_id] = 1'b1;
            end
          end else begin
            anext_d = cmd_i.arrival_next_tick;
            if (run_valid_q) begin
              state_d = ST_EXEC;
            end else if (any_wait) begin
              // Pop the head of the chosen level; its slot is read now.
              head_d[pick_lvl] = head_q[pick_lvl] + mlfq_pkg::SLOT_W'(1);
              cnt_d[pick_lvl]  = cnt_q[pick_lvl] - mlfq_pkg::CNT_W'(1);
              run_lvl_d        = pick_lvl;
              used_d           = '0;
              state_d          = ST_FETCH;
            end else begin
              // Nothing runnable.
              done_d = 1'b1;
              res_d  = '{idle: 1'b1, ran_id: '0, ran_level: '0,
                         finished: 1'b0, demoted: 1'b0};
            end
          end
        end
      end

      ST_FETCH: begin
        run_job_d   = fifo_rdata;
        run_valid_d = 1'b1;
        job_raddr   = fifo_rdata;
        state_d     = ST_EXEC;
      end

      ST_EXEC: begin
        job_we    = 1'b1;
        job_waddr = run_job_q;
        job_wdata = {rec_total, done_new};
        done_d    = 1'b1;
        res_d     = '{idle: 1'b0, ran_id: run_job_q, ran_level: run_lvl_q,
                      finished: fin, demoted: 1'b0};
        state_d   = ST_IDLE;
        if (fin) begin
          run_valid_d = 1'b0;
          used_d      = '0;
        end else if (expired) begin
          // Slice used up: requeue at the rear, one level down if allowed.
          res_d.demoted = can_dem;
          run_valid_d   = 1'b0;
          used_d        = '0;
          if (cnt_q[new_lvl] < CNT_FULL) begin
            fifo_we        = 1'b1;
            fifo_waddr     = {new_lvl, head_q[new_lvl] +
                              cnt_q[new_lvl][mlfq_pkg::SLOT_W-1:0]};
            fifo_wdata     = run_job_q;
            cnt_d[new_lvl] = cnt_q[new_lvl] + mlfq_pkg::CNT_W'(1);
          end
        end else begin
          used_d = used_new;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_valid_q <= 1'b0;
      run_job_q   <= '0;
      run_lvl_q   <= '0;
      used_q      <= '0;
      anext_q     <= 1'b0;
      jvalid_q    <= '0;
      done_q      <= 1'b0;
      for (int l = 0; l < mlfq_pkg::NUM_LEVELS; l++) begin
        head_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      run_valid_q <= run_valid_d;
      run_job_q   <= run_job_d;
      run_lvl_q   <= run_lvl_d;
      used_q      <= used_d;
      anext_q     <= anext_d;
      jvalid_q    <= jvalid_d;
      done_q      <= done_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== design/mlfq_chk.sv =====
// ----------------------------------------------------------------------------
// MLFQ tick scheduler checker
// Port-level properties of the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "mlfq_tick_scheduler_assert.svh"

module mlfq_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input mlfq_pkg::cmd_t cmd_i,
  input logic           done_o,
  input mlfq_pkg::res_t res_o
);

  // An idle result carries no job information.
  `MLFQ_ASSERT_IMP(a_idle_clean, done_o && res_o.idle, res_o.ran_id == '0 && res_o.ran_level == '0 && !res_o.finished && !res_o.demoted)

  // A job that retires is never demoted in the same tick.
  `MLFQ_ASSERT_IMP(a_fin_no_demote, done_o, !(res_o.finished && res_o.demoted))

  // An accepted arrive item produces no result in the following cycle.
  `MLFQ_ASSERT_NXT(a_arrive_silent, start_i && !busy_o && cmd_i.command == mlfq_pkg::CMD_ARRIVE, !done_o)

endmodule

bind mlfq_tick_scheduler mlfq_chk u_mlfq_chk (.*);
